// ===== rtl/twu_pkg.sv =====
// Shared types, constants and helper functions of the tetrapyd index walker.
// No dependencies; every other file of the block imports this package.
package twu_pkg;

	// Field and coordinate widths.
	localparam int unsigned FIELD_W   = 12;
	localparam int unsigned COORD_W   = 13;
	localparam int unsigned VAL_W     = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned MODE_W    = 2;

	// Every bound register is saturated to this limit before use.
	localparam logic [VAL_W-1:0] L_LIMIT = 16'd4095;

	// Geometry codes of the walk_mode register; the unused code walks as primordial.
	localparam logic [MODE_W-1:0] MODE_EQUAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_XXY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIM  = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_WALK_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_X   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_Y   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_X   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_Y   = 3'd4;

	// Signed working value: wide enough for exact sums of three coordinates.
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [FIELD_W-1:0] field_t;

	typedef struct packed {
		logic [MODE_W-1:0] walk_mode;
		field_t            lower_x;
		field_t            lower_y;
		field_t            upper_x;
		field_t            upper_y;
	} cfg_t;

	typedef struct packed {
		coord_t i;
		coord_t j;
		coord_t k;
		logic   more;
	} point_t;

	// Saturate a bound register to the multipole limit.
	function automatic val_t bound(input field_t r);
		logic [VAL_W-1:0] wide;
		wide = {{(VAL_W-FIELD_W){1'b0}}, r};
		if (wide > L_LIMIT) begin
			return val_t'(L_LIMIT);
		end
		return val_t'(wide);
	endfunction

	function automatic val_t from_field(input field_t f);
		return val_t'({{(VAL_W-FIELD_W){1'b0}}, f});
	endfunction

	function automatic val_t from_coord(input coord_t c);
		return val_t'({{(VAL_W-COORD_W){1'b0}}, c});
	endfunction

	// Parity of a value as a working value of 0 or 1.
	function automatic val_t par(input val_t v);
		return val_t'({{(VAL_W-1){1'b0}}, v[0]});
	endfunction

	function automatic val_t vmax(input val_t a, input val_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic val_t vmin(input val_t a, input val_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== rtl/twu_load.sv =====
// Load normaliser of the tetrapyd index walker: clamps, orders and legalises a start triple.
// Depends on twu_pkg.
module twu_load (
	input  twu_pkg::cfg_t   cfg,
	input  twu_pkg::field_t start_i,
	input  twu_pkg::field_t start_j,
	input  twu_pkg::field_t start_k,
	output twu_pkg::coord_t load_i,
	output twu_pkg::coord_t load_j,
	output twu_pkg::coord_t load_k
);
	import twu_pkg::*;

	val_t i, j, k, t, mx, my;

	always_comb begin
		mx = bound(cfg.lower_x);
		my = bound(cfg.lower_y);
		i  = from_field(start_i);
		j  = from_field(start_j);
		k  = from_field(start_k);
		t  = '0;
		unique case (cfg.walk_mode)
			MODE_XXY: begin
				// Two X multipoles ordered, Y multipole placed by triangle and parity.
				i = vmax(i, mx);
				j = vmax(j, mx);
				k = vmax(k, my);
				if (i > j) begin
					t = i; i = j; j = t;
				end
				if (i + j < k) begin
					if (i + j < my) begin
						if (my > (mx <<< 1)) begin
							i = my >>> 1;
							j = i + par(my);
							k = my;
						end else begin
							i = mx;
							j = mx;
							k = my + par(my);
						end
					end else begin
						k = i + j;
					end
				end else if (i + k < j) begin
					j = i + k;
				end else if (par(i + j + k) != '0) begin
					k = k + 1;
				end
			end
			default: begin
				// Equal-multipole and primordial geometries share the clamp and sort.
				i = vmax(i, mx);
				j = vmax(j, mx);
				k = vmax(k, mx);
				if (i > j) begin
					t = i; i = j; j = t;
				end
				if (j > k) begin
					t = j; j = k; k = t;
					if (i > j) begin
						t = i; i = j; j = t;
					end
				end
				if (cfg.walk_mode == MODE_EQUAL) begin
					if (i + j < k) begin
						k = i + j;
					end else if (par(i + j + k) != '0) begin
						k = k + 1;
					end
				end else if (i + j + 2 < k) begin
					k = i + j + 2;
				end
			end
		endcase
	end

	assign load_i = coord_t'(i);
	assign load_j = coord_t'(j);
	assign load_k = coord_t'(k);

endmodule

// ===== rtl/twu_step.sv =====
// Step logic of the tetrapyd index walker: next legal point after the current one, with end pin.
// Depends on twu_pkg.
module twu_step (
	input  twu_pkg::cfg_t   cfg,
	input  twu_pkg::coord_t cur_i,
	input  twu_pkg::coord_t cur_j,
	input  twu_pkg::coord_t cur_k,
	output twu_pkg::point_t next
);
	import twu_pkg::*;

	val_t i, j, k, m, mx, my, ny;
	logic more;

	always_comb begin
		i    = from_coord(cur_i);
		j    = from_coord(cur_j);
		k    = from_coord(cur_k);
		m    = bound(cfg.upper_x);
		mx   = m;
		my   = bound(cfg.upper_y);
		ny   = bound(cfg.lower_y);
		more = 1'b1;
		unique case (cfg.walk_mode)
			MODE_EQUAL: begin
				// Even-sum walk: k moves in steps of two until the triangle or bound stops it.
				if (par(i) + j == m) begin
					i = i + 1;
					j = i;
					k = j + par(i);
				end else if ((k + 2 > m) || (k >= i + j)) begin
					j = j + 1;
					k = j + par(i);
				end else begin
					k = k + 2;
				end
				if (i + j + k + 1 >= (m <<< 1) + m) begin
					more = 1'b0;
					i = (m[0] == 1'b0) ? m : m - 1;
					j = m;
					k = m;
				end
			end
			MODE_XXY: begin
				// Y multipole walks in steps of two below both the triangle and its bound.
				if ((j == mx) && (k + 2 > my)) begin
					i = i + 1;
					j = i;
					k = par(i + j) + ny;
				end else if (k + 2 > vmin(i + j, my)) begin
					j = j + 1;
					k = vmax(j - i, ny);
					k = k + par(i + j + k);
				end else begin
					k = k + 2;
				end
				if (i + j + k + 1 >= (mx <<< 1) + my) begin
					more = 1'b0;
					i = mx;
					j = mx;
					k = (my[0] == 1'b0) ? my : my - 1;
				end
			end
			default: begin
				// Primordial walk: unit steps with k up to i+j+2.
				if (j == m) begin
					i = i + 1;
					j = i;
					k = j;
				end else if ((k == m) || (k >= i + j + 2)) begin
					j = j + 1;
					k = j;
				end else begin
					k = k + 1;
				end
				if (i >= m) begin
					more = 1'b0;
					i = m;
					j = m;
					k = m;
				end
			end
		endcase
	end

	assign next.i    = coord_t'(i);
	assign next.j    = coord_t'(j);
	assign next.k    = coord_t'(k);
	assign next.more = more;

endmodule

// ===== rtl/tetrapyd_index_walker_unit.sv =====
// Tetrapyd index walker: one input register, single-pass load/step logic, one result register.
// Path: input register, then the load normaliser and step logic, then the result register.
// Throughput: one beat per cycle while the result port is not stalled.
// A held result does not stop the input side until the input register is also full.
// Reset (arst_n low, asynchronous) clears the configuration, the current point and all valids.
// Depends on twu_pkg, twu_load and twu_step.
module tetrapyd_index_walker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration writes.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twu_pkg::REG_IDX_W-1:0] cfg_index,
	input  twu_pkg::field_t               cfg_data,
	// Input beats.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // start_i[11:0], start_j[23:12], start_k[35:24]
	input  logic                          s_tuser,  // action
	// Result beats.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // point_i[12:0], point_j[25:13], point_k[38:26]
	output logic                          m_tuser   // more_points
);
	import twu_pkg::*;

	cfg_t   cfg_q;
	logic   valid_s1;
	logic   action_s1;
	field_t start_i_s1, start_j_s1, start_k_s1;
	coord_t cur_i_q, cur_j_q, cur_k_q;
	logic   out_valid_q;
	point_t out_q;
	coord_t load_i, load_j, load_k;
	point_t step_pt;
	point_t result;
	logic   in_acc;
	logic   move_s1;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WALK_MODE: cfg_q.walk_mode <= cfg_data[MODE_W-1:0];
				REG_LOWER_X:   cfg_q.lower_x   <= cfg_data;
				REG_LOWER_Y:   cfg_q.lower_y   <= cfg_data;
				REG_UPPER_X:   cfg_q.upper_x   <= cfg_data;
				REG_UPPER_Y:   cfg_q.upper_y   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is empty or being emptied.
	assign move_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1  <= s_tuser;
			start_i_s1 <= s_tdata[11:0];
			start_j_s1 <= s_tdata[23:12];
			start_k_s1 <= s_tdata[35:24];
		end
	end

	twu_load u_load (
		.cfg     (cfg_q),
		.start_i (start_i_s1),
		.start_j (start_j_s1),
		.start_k (start_k_s1),
		.load_i  (load_i),
		.load_j  (load_j),
		.load_k  (load_k)
	);

	twu_step u_step (
		.cfg   (cfg_q),
		.cur_i (cur_i_q),
		.cur_j (cur_j_q),
		.cur_k (cur_k_q),
		.next  (step_pt)
	);

	// A load always reports that the walk continues.
	always_comb begin
		if (action_s1) begin
			result = step_pt;
		end else begin
			result = '{i: load_i, j: load_j, k: load_k, more: 1'b1};
		end
	end

	// Current point and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_i_q     <= '0;
			cur_j_q     <= '0;
			cur_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			cur_i_q     <= result.i;
			cur_j_q     <= result.j;
			cur_k_q     <= result.k;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.k, out_q.j, out_q.i};
	assign m_tuser  = out_q.more;

	// An accepted beat is always held in the input register on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	// The input side only stalls when both registers are full and the result is held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	// A load result always says the walk continues.
	a_load_more: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && !action_s1) |=> (m_tvalid && m_tuser))
		else $error("load result reported end of walk");

	// The result register tracks the stored current point.
	a_out_matches_cur: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> (out_q.i == cur_i_q && out_q.j == cur_j_q && out_q.k == cur_k_q))
		else $error("result differs from the stored current point");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the tetrapyd index walker: drives load and advance beats,
// predicts every point in its own walk model and checks each result beat in order.
// Depends on twu_pkg and the tetrapyd_index_walker_unit RTL only.
`timescale 1ns / 1ps

module testbench;
	import twu_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
	localparam logic              ACT_LOAD    = 1'b0;
	localparam logic              ACT_ADVANCE = 1'b1;
	localparam int                CYCLE_LIMIT = 800000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	field_t               cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [39:0]          s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;
	logic                 m_tuser;

	// Mirror of the configuration and of the current point held by the block.
	logic [MODE_W-1:0] mode_mirror;
	field_t            lower_x_mirror, lower_y_mirror, upper_x_mirror, upper_y_mirror;
	coord_t            pos_i, pos_j, pos_k;
	logic              last_more;

	point_t pending_points[$];
	int              mismatch_count;
	int              cycle_count;
	bit              no_idle;
	int unsigned     hold_request;

	tetrapyd_index_walker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit; a hang ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clip_bound(input field_t r);
		return (r > L_LIMIT) ? longint'(L_LIMIT) : longint'(r);
	endfunction

	function automatic longint larger(input longint a, input longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint smaller(input longint a, input longint b);
		return (a < b) ? a : b;
	endfunction

	// Works out the point after one beat and updates the mirrored current point.
	function automatic point_t next_walk_point(input logic act, input field_t si,
			input field_t sj, input field_t sk);
		longint i, j, k, t, mx, my, ny, m;
		logic [MODE_W-1:0] md;
		logic more;
		point_t res;
		md = (mode_mirror == MODE_SPARE) ? MODE_PRIM : mode_mirror;
		more = 1'b1;
		if (act == ACT_LOAD) begin
			i = longint'(si);
			j = longint'(sj);
			k = longint'(sk);
			mx = clip_bound(lower_x_mirror);
			my = clip_bound(lower_y_mirror);
			if (md == MODE_XXY) begin
				i = larger(i, mx);
				j = larger(j, mx);
				k = larger(k, my);
				if (i > j) begin
					t = i; i = j; j = t;
				end
				if (i + j < k) begin
					if (i + j < my) begin
						if (my > 2 * mx) begin
							i = my / 2; j = i + my % 2; k = my;
						end else begin
							i = mx; j = mx; k = my + my % 2;
						end
					end else begin
						k = i + j;
					end
				end else if (i + k < j) begin
					j = i + k;
				end else if ((i + j + k) % 2 == 1) begin
					k = k + 1;
				end
			end else begin
				i = larger(i, mx);
				j = larger(j, mx);
				k = larger(k, mx);
				if (i > j) begin
					t = i; i = j; j = t;
				end
				if (j > k) begin
					t = j; j = k; k = t;
					if (i > j) begin
						t = i; i = j; j = t;
					end
				end
				if (md == MODE_EQUAL) begin
					if (i + j < k) k = i + j;
					else if ((i + j + k) % 2 == 1) k = k + 1;
				end else if (i + j + 2 < k) begin
					k = i + j + 2;
				end
			end
		end else begin
			i = longint'(pos_i);
			j = longint'(pos_j);
			k = longint'(pos_k);
			if (md == MODE_EQUAL) begin
				m = clip_bound(upper_x_mirror);
				if (i % 2 + j == m) begin
					i = i + 1; j = i; k = j + i % 2;
				end else if (k + 2 > m || k >= i + j) begin
					j = j + 1; k = j + i % 2;
				end else begin
					k = k + 2;
				end
				if (i + j + k + 1 >= 3 * m) begin
					more = 1'b0;
					i = (m % 2 == 0) ? m : m - 1; j = m; k = m;
				end
			end else if (md == MODE_XXY) begin
				mx = clip_bound(upper_x_mirror);
				my = clip_bound(upper_y_mirror);
				ny = clip_bound(lower_y_mirror);
				if (j == mx && k + 2 > my) begin
					i = i + 1; j = i; k = (i + j) % 2 + ny;
				end else if (k + 2 > smaller(i + j, my)) begin
					j = j + 1;
					k = larger(j - i, ny);
					k = k + (i + j + k) % 2;
				end else begin
					k = k + 2;
				end
				if (i + j + k + 1 >= 2 * mx + my) begin
					more = 1'b0;
					i = mx; j = mx; k = (my % 2 == 0) ? my : my - 1;
				end
			end else begin
				m = clip_bound(upper_x_mirror);
				if (j == m) begin
					i = i + 1; j = i; k = j;
				end else if (k == m || k >= i + j + 2) begin
					j = j + 1; k = j;
				end else begin
					k = k + 1;
				end
				if (i >= m) begin
					more = 1'b0;
					i = m; j = m; k = m;
				end
			end
		end
		// Coordinates are kept modulo 2^13.
		pos_i = i[COORD_W-1:0];
		pos_j = j[COORD_W-1:0];
		pos_k = k[COORD_W-1:0];
		last_more = more;
		res.i = pos_i;
		res.j = pos_j;
		res.k = pos_k;
		res.more = more;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100) begin
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		end
	endtask

	// Sends one beat after a random gap; tvalid is left high for a following beat.
	task automatic send_item(input logic act, input field_t si, input field_t sj,
			input field_t sk);
		int unsigned gap;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70) gap = 0;
		else if (r < 95) gap = $urandom_range(1, 3);
		else gap = $urandom_range(10, 30);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {4'b0000, sk, sj, si};
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_points.push_back(next_walk_point(act, si, sj, sk));
	endtask

	// Stops the input, lets every result drain and then writes all five registers.
	task automatic set_config(input field_t mode_word, input field_t lx, input field_t ly,
			input field_t ux, input field_t uy);
		logic [REG_IDX_W-1:0] regs[5];
		field_t vals[5];
		regs = '{REG_WALK_MODE, REG_LOWER_X, REG_LOWER_Y, REG_UPPER_X, REG_UPPER_Y};
		vals = '{mode_word, lx, ly, ux, uy};
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		for (int r = 0; r < 5; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[r];
			cfg_data <= vals[r];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			case (regs[r])
				REG_WALK_MODE: mode_mirror = vals[r][MODE_W-1:0];
				REG_LOWER_X:   lower_x_mirror = vals[r];
				REG_LOWER_Y:   lower_y_mirror = vals[r];
				REG_UPPER_X:   upper_x_mirror = vals[r];
				default:       upper_y_mirror = vals[r];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, quiet stretches and requested long hold-offs.
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned r;
		hold_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				end
			end
		end
	end

	// Each result beat is checked against the oldest predicted point.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected (%0d,%0d,%0d)",
					m_tdata[12:0], m_tdata[25:13], m_tdata[38:26]));
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[12:0] !== want.i)
					report_mismatch($sformatf("point_i got %0d expected %0d",
						m_tdata[12:0], want.i));
				if (m_tdata[25:13] !== want.j)
					report_mismatch($sformatf("point_j got %0d expected %0d",
						m_tdata[25:13], want.j));
				if (m_tdata[38:26] !== want.k)
					report_mismatch($sformatf("point_k got %0d expected %0d",
						m_tdata[38:26], want.k));
				if (m_tuser !== want.more)
					report_mismatch($sformatf("more_points got %b expected %b",
						m_tuser, want.more));
			end
		end
	end

	// Advance straight out of reset, then loads of the extreme triples with zero bounds and a last advance.
	task automatic test_reset_state();
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		send_item(ACT_LOAD, 12'd0, 12'd0, 12'd0);
		send_item(ACT_LOAD, 12'd4095, 12'd4095, 12'd4095);
		send_item(ACT_ADVANCE, 12'd4095, 12'd4095, 12'd4095);
	endtask

	// Load branches in every geometry, end points at the largest bound and the spare mode.
	task automatic test_directed();
		set_config(field_t'(MODE_EQUAL), 12'd2, 12'd0, 12'd9, 12'd0);
		send_item(ACT_LOAD, 12'd7, 12'd3, 12'd5);
		send_item(ACT_LOAD, 12'd3, 12'd3, 12'd9);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		set_config(field_t'(MODE_EQUAL), 12'd0, 12'd0, 12'd4095, 12'd4095);
		send_item(ACT_LOAD, 12'd4095, 12'd4095, 12'd4095);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		set_config(field_t'(MODE_XXY), 12'd3, 12'd20, 12'd6, 12'd25);
		send_item(ACT_LOAD, 12'd0, 12'd0, 12'd0);
		send_item(ACT_LOAD, 12'd3, 12'd30, 12'd20);
		send_item(ACT_LOAD, 12'd5, 12'd16, 12'd25);
		send_item(ACT_LOAD, 12'd6, 12'd7, 12'd20);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		set_config(field_t'(MODE_PRIM), 12'd0, 12'd0, 12'd4095, 12'd0);
		send_item(ACT_LOAD, 12'd4095, 12'd0, 12'd0);
		send_item(ACT_LOAD, 12'd4095, 12'd4095, 12'd4095);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		// Spare mode code with junk in the upper data bits; the first step is from a stale point.
		set_config({10'h3FF, MODE_SPARE}, 12'd1, 12'd0, 12'd3, 12'd0);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		send_item(ACT_LOAD, 12'd0, 12'd1, 12'd2);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		set_config(field_t'(MODE_EQUAL), 12'd0, 12'd0, 12'd3, 12'd0);
		send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
	endtask

	// Walks over small regions in every geometry, up to 300 advances each, then two more advances.
	task automatic test_walks();
		field_t lx, ly, ux, uy;
		int steps;
		for (int round = 0; round < 8; round++) begin
			lx = field_t'($urandom_range(0, 6));
			ux = lx + field_t'($urandom_range(0, 8));
			ly = field_t'($urandom_range(0, 6));
			uy = ly + field_t'($urandom_range(0, 10));
			set_config(field_t'(round % 4), lx, ly, ux, uy);
			send_item(ACT_LOAD, lx, lx, ly);
			steps = 0;
			while (last_more && steps < 300) begin
				send_item(ACT_ADVANCE, field_t'($urandom), field_t'($urandom),
					field_t'($urandom));
				steps++;
			end
			send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
			send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		end
	endtask

	// The receiver holds off for a long stretch while beats keep coming.
	task automatic test_backpressure();
		set_config(field_t'(MODE_XXY), 12'd2, 12'd4, 12'd40, 12'd60);
		send_item(ACT_LOAD, 12'd0, 12'd0, 12'd0);
		no_idle = 1'b1;
		hold_request = 300;
		repeat (40) send_item(ACT_ADVANCE, 12'd0, 12'd0, 12'd0);
		no_idle = 1'b0;
	endtask

	// Random phases: mostly advances along walks, with loads near the bounds or anywhere.
	task automatic test_random();
		field_t mode_word, lx, ly, ux, uy;
		int unsigned r;
		for (int p = 0; p < 12; p++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				lx = field_t'($urandom_range(0, 30));
				ux = lx + field_t'($urandom_range(0, 15));
				ly = field_t'($urandom_range(0, 30));
				uy = ly + field_t'($urandom_range(0, 15));
			end else if (r < 85) begin
				lx = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				ux = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				ly = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				uy = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			end else begin
				lx = field_t'($urandom);
				ux = field_t'($urandom);
				ly = field_t'($urandom);
				uy = field_t'($urandom);
			end
			mode_word = ($urandom_range(0, 3) == 0) ? field_t'($urandom)
				: field_t'($urandom_range(0, 3));
			set_config(mode_word, lx, ly, ux, uy);
			no_idle = (p % 4 == 3);
			repeat (110) begin
				if ($urandom_range(0, 99) < 18) begin
					if ($urandom_range(0, 1))
						send_item(ACT_LOAD, lx + field_t'($urandom_range(0, 20)),
							lx + field_t'($urandom_range(0, 20)),
							ly + field_t'($urandom_range(0, 20)));
					else
						send_item(ACT_LOAD, field_t'($urandom), field_t'($urandom),
							field_t'($urandom));
				end else begin
					send_item(ACT_ADVANCE, field_t'($urandom), field_t'($urandom),
						field_t'($urandom));
				end
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WALK_MODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_LOAD;
		mode_mirror = MODE_EQUAL;
		lower_x_mirror = '0;
		lower_y_mirror = '0;
		upper_x_mirror = '0;
		upper_y_mirror = '0;
		pos_i = '0;
		pos_j = '0;
		pos_k = '0;
		last_more = 1'b1;
		mismatch_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_request = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed();
		test_walks();
		test_backpressure();
		test_random();

		// Drain every outstanding point, then allow for the pipeline depth.
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
